/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the target ramp interpolator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define TRP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every rising edge, reset included.
`define TRP_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/trp_pkg.sv */
// ----------------------------------------------------------------------------
// trp_pkg
// Types, codes and constants shared by the target ramp interpolator modules.
// ----------------------------------------------------------------------------
package trp_pkg;

   // Field widths.
   localparam int VALUE_BITS        = 31;
   localparam int ELAPSED_BITS      = 16;
   localparam int RATE_BITS         = 32;
   localparam int RATE_POINT        = 16;
   localparam int SCALE_BITS        = 16;
   localparam int SEL_BITS          = 2;
   localparam int FRACTION_BITS_DEF = 16;

   // Arithmetic sizing.
   localparam int MUL_BITS     = 32;
   localparam int WHOLE_BITS   = 33;
   localparam int DIV_REM_BITS = 14;
   localparam int DIV_LINEAR   = 100;
   localparam int DIV_RELATIVE = 10000;

   // Register port.
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;
   localparam int REG_IDX_BITS  = CSR_ADDR_BITS - 2;

   localparam logic [REG_IDX_BITS-1:0] REG_MODE_TYPE     = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_LIMIT_MODE    = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_FACTOR_KIND   = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_CLAMP_ENABLES = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_UPPER_BOUND   = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_LOWER_BOUND   = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_SCALE_FACTOR  = 3'd6;
   localparam logic [REG_IDX_BITS-1:0] REG_RATE          = 3'd7;

   // Operation codes.
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_GOAL     = 2'd1;
   localparam logic [1:0] OP_POSITION = 2'd2;

   // Mode codes.
   localparam logic [SEL_BITS-1:0] MODE_LIMIT    = 2'd1;
   localparam logic [SEL_BITS-1:0] MODE_RELATIVE = 2'd2;
   localparam logic [SEL_BITS-1:0] MODE_ABSOLUTE = 2'd3;

   localparam logic [SEL_BITS-1:0] LIMIT_NONE = 2'd0;
   localparam logic [SEL_BITS-1:0] LIMIT_INC  = 2'd1;
   localparam logic [SEL_BITS-1:0] LIMIT_DEC  = 2'd2;

   localparam logic [SEL_BITS-1:0] FACTOR_RELATIVE = 2'd1;
   localparam logic [SEL_BITS-1:0] FACTOR_LINEAR   = 2'd2;

   localparam int CLAMP_UPPER_BIT = 0;
   localparam int CLAMP_LOWER_BIT = 1;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd1;

   // Datapath commands.
   localparam int CMD_BITS = 4;
   localparam logic [CMD_BITS-1:0] CMD_IDLE     = 4'd0;
   localparam logic [CMD_BITS-1:0] CMD_MUL_RE   = 4'd1;
   localparam logic [CMD_BITS-1:0] CMD_MUL_LO   = 4'd2;
   localparam logic [CMD_BITS-1:0] CMD_MUL_HI   = 4'd3;
   localparam logic [CMD_BITS-1:0] CMD_ACCUM    = 4'd4;
   localparam logic [CMD_BITS-1:0] CMD_LOAD_LIN = 4'd5;
   localparam logic [CMD_BITS-1:0] CMD_DIV_INIT = 4'd6;
   localparam logic [CMD_BITS-1:0] CMD_DIV_STEP = 4'd7;
   localparam logic [CMD_BITS-1:0] CMD_SUM      = 4'd8;
   localparam logic [CMD_BITS-1:0] CMD_MOVE     = 4'd9;
   localparam logic [CMD_BITS-1:0] CMD_TICK_END = 4'd10;
   localparam logic [CMD_BITS-1:0] CMD_GOAL     = 4'd11;
   localparam logic [CMD_BITS-1:0] CMD_SCALE_UB = 4'd12;
   localparam logic [CMD_BITS-1:0] CMD_SCALE_LB = 4'd13;
   localparam logic [CMD_BITS-1:0] CMD_POS_LOAD = 4'd14;

   typedef struct packed {
      logic [1:0]              operation;
      logic [ELAPSED_BITS-1:0] elapsed;
      logic [VALUE_BITS-1:0]   new_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] position;
      logic [VALUE_BITS-1:0] goal;
      logic                  reached;
   } rsp_type;

   typedef struct packed {
      logic [SEL_BITS-1:0]   mode_type;
      logic [SEL_BITS-1:0]   limit_mode;
      logic [SEL_BITS-1:0]   factor_kind;
      logic [SEL_BITS-1:0]   clamp_enables;
      logic [VALUE_BITS-1:0] upper_bound;
      logic [VALUE_BITS-1:0] lower_bound;
      logic [SCALE_BITS-1:0] scale_factor;
      logic [RATE_BITS-1:0]  rate;
   } cfg_type;

   // Controller to datapath.
   typedef struct packed {
      logic                capture;
      logic                emit;
      logic [CMD_BITS-1:0] cmd;
   } ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic [1:0] operation;
      logic       step_go;
      logic       relative;
   } sts_type;

   // Radix-4 divider steps for a quotient of frac_bits + WHOLE_BITS bits.
   function automatic int div_steps(input int frac_bits);
      return (frac_bits + WHOLE_BITS + 1) / 2;
   endfunction

endpackage

/* rtl/target_ramp_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// target_ramp_interpolator_unit
// Moves a stored position toward a stored goal on each tick in limit mode, with linear or
// distance-proportional steps, fraction carry, snap and clamp rules.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns one result beat per item.
// A tick that moves the position in limit mode runs the shared 32x32
// multiplier (rate times elapsed, and for a relative step also times the
// distance), then S radix-4 divider iterations, where S = ceil((FRAC_BITS +
// 33) / 2) (S = 25 at the default FRAC_BITS of 16), then the sum, move and
// tick end steps. A goal load, a position load, a tick that takes no step and
// an unused operation code do not use the divider. The next item is accepted
// the cycle after the result is placed in the output register, which holds it
// until taken.
// FRAC_BITS sets the width of the kept step fraction and may range from 8 to
// 24. There is no clearing pass after reset.
`include "assert_macros.svh"

module target_ramp_interpolator_unit
   import trp_pkg::*;
#(
   parameter int FRAC_BITS = FRACTION_BITS_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type cfg;
   ctl_type ctl;
   sts_type sts;

   // Configuration registers.
   trp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer.
   trp_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // Arithmetic and state.
   trp_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_data (req_data),
      .ctl      (ctl),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   // Only one item is in flight at a time.
   `TRP_ASSERT(a_one_in_flight, (req_valid && !req_stall) |=> req_stall, "second item taken while busy")
   // A result is loaded only when the output register is free.
   `TRP_ASSERT(a_emit_when_free, ctl.emit |-> (!rsp_valid || !rsp_stall), "result overwrote a held beat")
   // A new output beat always comes from an emit.
   `TRP_ASSERT(a_valid_from_emit, $rose(rsp_valid) |-> $past(ctl.emit), "output valid without an emit")
   // Reset empties the output register.
   `TRP_ASSERT_RST(a_reset_clears, reset |=> !rsp_valid, "output valid after reset")

endmodule

/* rtl/trp_csr.sv */
// ----------------------------------------------------------------------------
// trp_csr
// Configuration registers behind an APB-style port with read back.
// ----------------------------------------------------------------------------
module trp_csr
   import trp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic [REG_IDX_BITS-1:0] reg_idx;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MODE_TYPE:     cfg_in.mode_type     = csr_pwdata[SEL_BITS-1:0];
            REG_LIMIT_MODE:    cfg_in.limit_mode    = csr_pwdata[SEL_BITS-1:0];
            REG_FACTOR_KIND:   cfg_in.factor_kind   = csr_pwdata[SEL_BITS-1:0];
            REG_CLAMP_ENABLES: cfg_in.clamp_enables = csr_pwdata[SEL_BITS-1:0];
            REG_UPPER_BOUND:   cfg_in.upper_bound   = csr_pwdata[VALUE_BITS-1:0];
            REG_LOWER_BOUND:   cfg_in.lower_bound   = csr_pwdata[VALUE_BITS-1:0];
            REG_SCALE_FACTOR:  cfg_in.scale_factor  = csr_pwdata[SCALE_BITS-1:0];
            REG_RATE:          cfg_in.rate          = csr_pwdata[RATE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Read back mux.
   always_comb begin
      case (reg_idx)
         REG_MODE_TYPE:     csr_prdata = CSR_DATA_BITS'(cfg_ff.mode_type);
         REG_LIMIT_MODE:    csr_prdata = CSR_DATA_BITS'(cfg_ff.limit_mode);
         REG_FACTOR_KIND:   csr_prdata = CSR_DATA_BITS'(cfg_ff.factor_kind);
         REG_CLAMP_ENABLES: csr_prdata = CSR_DATA_BITS'(cfg_ff.clamp_enables);
         REG_UPPER_BOUND:   csr_prdata = CSR_DATA_BITS'(cfg_ff.upper_bound);
         REG_LOWER_BOUND:   csr_prdata = CSR_DATA_BITS'(cfg_ff.lower_bound);
         REG_SCALE_FACTOR:  csr_prdata = CSR_DATA_BITS'(cfg_ff.scale_factor);
         REG_RATE:          csr_prdata = CSR_DATA_BITS'(cfg_ff.rate);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_type     <= MODE_ABSOLUTE;
         cfg_ff.limit_mode    <= LIMIT_NONE;
         cfg_ff.factor_kind   <= FACTOR_LINEAR;
         cfg_ff.clamp_enables <= '0;
         cfg_ff.upper_bound   <= '0;
         cfg_ff.lower_bound   <= '0;
         cfg_ff.scale_factor  <= SCALE_RESET;
         cfg_ff.rate          <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/trp_ctrl.sv */
// ----------------------------------------------------------------------------
// trp_ctrl
// Sequencer for the ramp interpolator: takes one item, walks the datapath
// through its steps and hands the result to the output register.
// ----------------------------------------------------------------------------
module trp_ctrl
   import trp_pkg::*;
#(
   parameter int FRAC_BITS = FRACTION_BITS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output ctl_type ctl
);

   localparam int DIV_STEPS = div_steps(FRAC_BITS);
   localparam int CNT_BITS  = $clog2(DIV_STEPS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_STEPS - 1);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DECODE   = 5'd1;
   localparam logic [4:0] S_MUL_RE   = 5'd2;
   localparam logic [4:0] S_MUL_LO   = 5'd3;
   localparam logic [4:0] S_MUL_HI   = 5'd4;
   localparam logic [4:0] S_ACCUM    = 5'd5;
   localparam logic [4:0] S_LOAD_LIN = 5'd6;
   localparam logic [4:0] S_DIV_INIT = 5'd7;
   localparam logic [4:0] S_DIV_STEP = 5'd8;
   localparam logic [4:0] S_SUM      = 5'd9;
   localparam logic [4:0] S_MOVE     = 5'd10;
   localparam logic [4:0] S_TICK_END = 5'd11;
   localparam logic [4:0] S_GOAL     = 5'd12;
   localparam logic [4:0] S_SCALE_UB = 5'd13;
   localparam logic [4:0] S_SCALE_LB = 5'd14;
   localparam logic [4:0] S_POS_LOAD = 5'd15;
   localparam logic [4:0] S_EMIT     = 5'd16;

   logic [4:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath command.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ctl      = '0;
      ctl.cmd  = CMD_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.operation)
               OP_TICK:     state_in = sts.step_go ? S_MUL_RE : S_TICK_END;
               OP_GOAL:     state_in = S_GOAL;
               OP_POSITION: state_in = S_SCALE_UB;
               default:     state_in = S_EMIT;
            endcase
         end
         S_MUL_RE: begin
            ctl.cmd  = CMD_MUL_RE;
            state_in = sts.relative ? S_MUL_LO : S_LOAD_LIN;
         end
         S_MUL_LO: begin
            ctl.cmd  = CMD_MUL_LO;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            ctl.cmd  = CMD_MUL_HI;
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            ctl.cmd  = CMD_ACCUM;
            state_in = S_DIV_INIT;
         end
         S_LOAD_LIN: begin
            ctl.cmd  = CMD_LOAD_LIN;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            ctl.cmd  = CMD_DIV_INIT;
            cnt_in   = '0;
            state_in = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            ctl.cmd = CMD_DIV_STEP;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_SUM;
            end else begin
               cnt_in = CNT_BITS'(cnt_ff + 1'b1);
            end
         end
         S_SUM: begin
            ctl.cmd  = CMD_SUM;
            state_in = S_MOVE;
         end
         S_MOVE: begin
            ctl.cmd  = CMD_MOVE;
            state_in = S_TICK_END;
         end
         S_TICK_END: begin
            ctl.cmd  = CMD_TICK_END;
            state_in = S_EMIT;
         end
         S_GOAL: begin
            ctl.cmd  = CMD_GOAL;
            state_in = S_EMIT;
         end
         S_SCALE_UB: begin
            ctl.cmd  = CMD_SCALE_UB;
            state_in = S_SCALE_LB;
         end
         S_SCALE_LB: begin
            ctl.cmd  = CMD_SCALE_LB;
            state_in = S_POS_LOAD;
         end
         S_POS_LOAD: begin
            ctl.cmd  = CMD_POS_LOAD;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // Wait here while the previous result is still held.
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output beat valid: set on emit, cleared once the beat is taken.
   assign rsp_valid_in = ctl.emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/trp_dp.sv */
// ----------------------------------------------------------------------------
// trp_dp
// Ramp interpolator datapath: position, goal and fraction state, a shared
// 32x32 multiplier, a radix-4 divider by a constant and the result register.
// ----------------------------------------------------------------------------
module trp_dp
   import trp_pkg::*;
#(
   parameter int FRAC_BITS = FRACTION_BITS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  req_type req_data,
   input  ctl_type ctl,
   output sts_type sts,
   output rsp_type rsp_data
);

   localparam int RE_BITS     = RATE_BITS + ELAPSED_BITS;
   localparam int ACC_BITS    = RE_BITS + VALUE_BITS;
   localparam int SHL         = (FRAC_BITS > RATE_POINT) ? FRAC_BITS - RATE_POINT : 0;
   localparam int SHR         = (FRAC_BITS < RATE_POINT) ? RATE_POINT - FRAC_BITS : 0;
   localparam int NUM_BITS    = ACC_BITS + SHL;
   localparam int Q_BITS      = FRAC_BITS + WHOLE_BITS;
   localparam int QE_BITS     = 2 * div_steps(FRAC_BITS);
   localparam int SUM_BITS    = Q_BITS + 1;
   localparam int STEP_BITS   = SUM_BITS - FRAC_BITS;
   localparam int PART_BITS   = DIV_REM_BITS + 2;
   localparam int PROD_BITS   = 2 * MUL_BITS;
   localparam int SCALED_BITS = VALUE_BITS + SCALE_BITS;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
   localparam logic [Q_BITS-1:0]     STEP_CAP  = {Q_BITS{1'b1}};

   // Item and architectural state.
   logic [1:0]              op_ff, op_in;
   logic [ELAPSED_BITS-1:0] elapsed_ff, elapsed_in;
   logic [VALUE_BITS-1:0]   value_ff, value_in;
   logic [VALUE_BITS-1:0]   pos_ff, pos_in;
   logic [VALUE_BITS-1:0]   goal_ff, goal_in;
   logic [FRAC_BITS-1:0]    frac_ff, frac_in;

   // Working registers.
   logic [VALUE_BITS-1:0]   dist_ff, dist_in;
   logic                    up_ff, up_in;
   logic [RE_BITS-1:0]      re_ff, re_in;
   logic [ACC_BITS-1:0]     acc_ff, acc_in;
   logic [SCALED_BITS-1:0]  hi_ff, hi_in;
   logic                    sat_ff, sat_in;
   logic [DIV_REM_BITS-1:0] rem_ff, rem_in;
   logic [QE_BITS-1:0]      div_ff, div_in;
   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [VALUE_BITS-1:0]   sub_ff, sub_in;
   logic [VALUE_BITS-1:0]   slb_ff, slb_in;
   rsp_type                 rsp_ff, rsp_in;

   // Combinational helpers.
   logic [MUL_BITS-1:0]     mul_a, mul_b;
   logic [PROD_BITS-1:0]    mul_p;
   logic [VALUE_BITS-1:0]   scaled_sat;
   logic [NUM_BITS-1:0]     num;
   logic [PART_BITS-1:0]    dvs1, dvs2, dvs3;
   logic [PART_BITS-1:0]    part, part_left;
   logic [1:0]              digit;
   logic [Q_BITS-1:0]       step_val;
   logic [STEP_BITS-1:0]    whole;
   logic [VALUE_BITS-1:0]   pos_load;

   assign rsp_data = rsp_ff;

   // Status for the controller.
   assign sts.operation = op_ff;
   assign sts.relative  = (cfg.factor_kind == FACTOR_RELATIVE);
   assign sts.step_go   = (cfg.mode_type == MODE_LIMIT)
                        && (cfg.factor_kind == FACTOR_RELATIVE
                            || cfg.factor_kind == FACTOR_LINEAR)
                        && (pos_ff != goal_ff) && (elapsed_ff != '0);

   // Shared multiplier operand select.
   always_comb begin
      case (ctl.cmd)
         CMD_MUL_RE: begin
            mul_a = MUL_BITS'(cfg.rate);
            mul_b = MUL_BITS'(elapsed_ff);
         end
         CMD_MUL_LO: begin
            mul_a = re_ff[MUL_BITS-1:0];
            mul_b = MUL_BITS'(dist_ff);
         end
         CMD_MUL_HI: begin
            mul_a = MUL_BITS'(re_ff[RE_BITS-1:MUL_BITS]);
            mul_b = MUL_BITS'(dist_ff);
         end
         CMD_SCALE_UB: begin
            mul_a = MUL_BITS'(cfg.upper_bound);
            mul_b = MUL_BITS'(cfg.scale_factor);
         end
         CMD_SCALE_LB: begin
            mul_a = MUL_BITS'(cfg.lower_bound);
            mul_b = MUL_BITS'(cfg.scale_factor);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

   // A scaled bound saturates to the largest position.
   assign scaled_sat = (mul_p[SCALED_BITS-1:0] > SCALED_BITS'(VALUE_MAX))
                     ? VALUE_MAX : mul_p[VALUE_BITS-1:0];

   // Dividend aligned to the fraction point of the step.
   assign num = (NUM_BITS'(acc_ff) << SHL) >> SHR;

   // Divisor multiples for the radix-4 digit select.
   assign dvs1 = sts.relative ? PART_BITS'(DIV_RELATIVE) : PART_BITS'(DIV_LINEAR);
   assign dvs2 = PART_BITS'(dvs1 << 1);
   assign dvs3 = PART_BITS'(dvs1 + dvs2);

   // One radix-4 division step.
   always_comb begin
      part = {rem_ff, div_ff[QE_BITS-1 -: 2]};
      if (part >= dvs3) begin
         digit     = 2'd3;
         part_left = PART_BITS'(part - dvs3);
      end else if (part >= dvs2) begin
         digit     = 2'd2;
         part_left = PART_BITS'(part - dvs2);
      end else if (part >= dvs1) begin
         digit     = 2'd1;
         part_left = PART_BITS'(part - dvs1);
      end else begin
         digit     = 2'd0;
         part_left = part;
      end
   end

   assign step_val = sat_ff ? STEP_CAP : div_ff[Q_BITS-1:0];
   assign whole    = sum_ff[SUM_BITS-1:FRAC_BITS];

   // Position load: upper clamp first, then lower.
   always_comb begin
      pos_load = value_ff;
      if (cfg.clamp_enables[CLAMP_UPPER_BIT] && pos_load > sub_ff) begin
         pos_load = sub_ff;
      end
      if (cfg.clamp_enables[CLAMP_LOWER_BIT] && pos_load < slb_ff) begin
         pos_load = slb_ff;
      end
   end

   // Register updates per command.
   always_comb begin
      op_in      = op_ff;
      elapsed_in = elapsed_ff;
      value_in   = value_ff;
      pos_in     = pos_ff;
      goal_in    = goal_ff;
      frac_in    = frac_ff;
      dist_in    = dist_ff;
      up_in      = up_ff;
      re_in      = re_ff;
      acc_in     = acc_ff;
      hi_in      = hi_ff;
      sat_in     = sat_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      sum_in     = sum_ff;
      sub_in     = sub_ff;
      slb_in     = slb_ff;
      rsp_in     = rsp_ff;

      // Item capture also freezes the distance to the goal.
      if (ctl.capture) begin
         op_in      = req_data.operation;
         elapsed_in = req_data.elapsed;
         value_in   = req_data.new_value;
         up_in      = (pos_ff < goal_ff);
         dist_in    = (pos_ff < goal_ff) ? VALUE_BITS'(goal_ff - pos_ff)
                                         : VALUE_BITS'(pos_ff - goal_ff);
      end

      if (ctl.emit) begin
         rsp_in.position = pos_ff;
         rsp_in.goal     = goal_ff;
         rsp_in.reached  = (pos_ff == goal_ff);
      end

      case (ctl.cmd)
         CMD_MUL_RE:   re_in  = mul_p[RE_BITS-1:0];
         CMD_MUL_LO:   acc_in = ACC_BITS'(mul_p);
         CMD_MUL_HI:   hi_in  = mul_p[SCALED_BITS-1:0];
         CMD_ACCUM:    acc_in = ACC_BITS'(acc_ff + (ACC_BITS'(hi_ff) << MUL_BITS));
         CMD_LOAD_LIN: acc_in = ACC_BITS'(re_ff);
         CMD_DIV_INIT: begin
            // Quotient beyond the step cap saturates.
            sat_in = ((num >> Q_BITS) >= NUM_BITS'(dvs1));
            rem_in = DIV_REM_BITS'(num >> QE_BITS);
            div_in = num[QE_BITS-1:0];
         end
         CMD_DIV_STEP: begin
            rem_in = part_left[DIV_REM_BITS-1:0];
            div_in = {div_ff[QE_BITS-3:0], digit};
         end
         CMD_SUM: sum_in = SUM_BITS'(step_val) + SUM_BITS'(frac_ff);
         CMD_MOVE: begin
            // Reaching or passing the goal snaps and drops the fraction.
            if (whole >= STEP_BITS'(dist_ff)) begin
               pos_in  = goal_ff;
               frac_in = '0;
            end else begin
               pos_in  = up_ff ? VALUE_BITS'(pos_ff + whole[VALUE_BITS-1:0])
                               : VALUE_BITS'(pos_ff - whole[VALUE_BITS-1:0]);
               frac_in = sum_ff[FRAC_BITS-1:0];
            end
         end
         CMD_TICK_END: begin
            case (cfg.mode_type)
               MODE_LIMIT: begin
                  case (cfg.limit_mode)
                     LIMIT_INC: begin
                        if (goal_ff <= pos_ff) begin
                           pos_in = goal_ff;
                        end
                     end
                     LIMIT_DEC: begin
                        if (goal_ff >= pos_ff) begin
                           pos_in = goal_ff;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               MODE_RELATIVE, MODE_ABSOLUTE: begin
                  if (pos_ff > goal_ff) begin
                     pos_in = goal_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         CMD_GOAL: begin
            // The upper bound wins when both apply.
            if (cfg.clamp_enables[CLAMP_UPPER_BIT] && value_ff > cfg.upper_bound) begin
               goal_in = cfg.upper_bound;
            end else if (cfg.clamp_enables[CLAMP_LOWER_BIT]
                         && value_ff < cfg.lower_bound) begin
               goal_in = cfg.lower_bound;
            end else begin
               goal_in = value_ff;
            end
         end
         CMD_SCALE_UB: sub_in = scaled_sat;
         CMD_SCALE_LB: slb_in = scaled_sat;
         CMD_POS_LOAD: pos_in = pos_load;
         default: begin
         end
      endcase
   end

   // Architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         goal_ff <= '0;
         frac_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         goal_ff <= goal_in;
         frac_ff <= frac_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      elapsed_ff <= elapsed_in;
      value_ff   <= value_in;
      dist_ff    <= dist_in;
      up_ff      <= up_in;
      re_ff      <= re_in;
      acc_ff     <= acc_in;
      hi_ff      <= hi_in;
      sat_ff     <= sat_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      sum_ff     <= sum_in;
      sub_ff     <= sub_in;
      slb_ff     <= slb_in;
      rsp_ff     <= rsp_in;
   end

endmodule
